### design/atr_pkg.sv
// ----------------------------------------------------------------------------
// atr_pkg: shared constants for the ATR byte parser
// Operation codes and fixed byte values used by the interfaces and the parser.
// ----------------------------------------------------------------------------
package atr_pkg;

    // Operation carried with each input transaction
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_BYTE    = 1'b1;

    // Initial character for direct convention
    localparam logic [7:0] TS_DIRECT   = 8'h3B;
    // Reported when TA1 is absent
    localparam logic [7:0] TA1_DEFAULT = 8'h11;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PROTO_W = 16;

endpackage

### design/atr_in_if.sv
// ----------------------------------------------------------------------------
// atr_in_if: input channel of the ATR byte parser
// Carries one operation and one received byte per transaction.
// ----------------------------------------------------------------------------
interface atr_in_if
    import atr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

### design/atr_out_if.sv
// ----------------------------------------------------------------------------
// atr_out_if: result channel of the ATR byte parser
// Carries the parse status after each input transaction.
// ----------------------------------------------------------------------------
interface atr_out_if
    import atr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               error;
    logic               complete;
    logic [BYTE_W-1:0]  received_count;
    logic [PROTO_W-1:0] offered_protocols;
    logic [BYTE_W-1:0]  ta1_value;

    modport source (output valid, output error, output complete, output received_count,
                    output offered_protocols, output ta1_value, input ready);
    modport sink   (input valid, input error, input complete, input received_count,
                    input offered_protocols, input ta1_value, output ready);
endinterface

### design/atr_byte_parser.sv
// ----------------------------------------------------------------------------
// atr_byte_parser: ISO 7816 Answer-To-Reset byte parser
// Follows the ATR structure byte by byte and reports status per byte.
// ----------------------------------------------------------------------------
// Usage:
//   bytes   : input channel. op = OP_RESTART starts a new ATR (data_byte is
//             ignored), op = OP_BYTE delivers one received ATR byte.
//   results : one transaction per input transaction, in order: error flag,
//             complete flag, byte count, offered protocol mask and TA1.
// Output: a byte's result is registered and presented in the cycle after it.
// Throughput: one byte per cycle unless stalled. The parse state is
//   updated by a single level of logic on each accepted byte and the
//   result is held in one output register; a new byte enters as it empties.
// Stall: when the receiver holds ready low with a result pending, bytes.ready
//   drops until that result is taken; no result is lost or repeated.
// Reset: rst_n clears the parse state to "expecting TS" and empties the
//   output register. A restart operation has the same effect on the parse
//   state and also produces a result (no error, count zero, TA1 0x11).
// ----------------------------------------------------------------------------
module atr_byte_parser
    import atr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    atr_in_if.sink    bytes,
    atr_out_if.source results
);

    typedef enum logic [2:0] {
        KIND_TS,
        KIND_T0,
        KIND_IFACE,
        KIND_HIST,
        KIND_TCK,
        KIND_DONE
    } kind_t;

    // Parse state
    kind_t              kind_reg,      kind_next;
    logic [7:0]         total_reg,     total_next;
    logic [7:0]         expect_reg,    expect_next;
    logic [3:0]         pres_reg,      pres_next;
    logic               fmt_seen_reg,  fmt_seen_next;
    logic [2:0]         gpos_reg,      gpos_next;
    logic [3:0]         hist_reg,      hist_next;
    logic [PROTO_W-1:0] mask_reg,      mask_next;
    logic               dflt_reg,      dflt_next;
    logic [7:0]         check_reg,     check_next;
    logic [7:0]         fmt_byte_reg,  fmt_byte_next;
    logic [7:0]         third_reg,     third_next;

    // Result register
    logic               out_valid_reg;
    logic               err_reg;
    logic               complete_reg;
    logic [7:0]         count_reg;
    logic [PROTO_W-1:0] proto_reg;
    logic [7:0]         ta1_reg;

    logic               accept;
    logic               err;
    logic               iface;
    logic               hdr_err;
    logic               found;
    logic [2:0]         steps;
    logic [2:0]         span;
    logic [7:0]         b;

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] n);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, n};
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

    assign bytes.ready = !out_valid_reg || results.ready;
    assign accept      = bytes.valid && bytes.ready;
    assign b           = bytes.data_byte;

    always_comb
    begin
        kind_next     = kind_reg;
        total_next    = total_reg;
        expect_next   = expect_reg;
        pres_next     = pres_reg;
        fmt_seen_next = fmt_seen_reg;
        gpos_next     = gpos_reg;
        hist_next     = hist_reg;
        mask_next     = mask_reg;
        dflt_next     = dflt_reg;
        check_next    = check_reg;
        fmt_byte_next = fmt_byte_reg;
        third_next    = third_reg;
        err           = 1'b0;
        iface         = 1'b0;
        hdr_err       = 1'b0;
        found         = 1'b0;
        steps         = 3'd0;
        span          = 3'd0;

        if (bytes.op == OP_RESTART)
        begin
            kind_next     = KIND_TS;
            total_next    = 8'd0;
            expect_next   = 8'd2;
            pres_next     = 4'd0;
            fmt_seen_next = 1'b0;
            gpos_next     = 3'd4;
            hist_next     = 4'd0;
            mask_next     = '0;
            dflt_next     = 1'b1;
            check_next    = 8'd0;
            fmt_byte_next = 8'd0;
            third_next    = 8'd0;
        end
        else if (total_reg == 8'hFF)
        begin
            // count is full: flag and drop the byte
            err = 1'b1;
        end
        else
        begin
            if (total_reg == 8'd1)
                fmt_byte_next = b;
            if (total_reg == 8'd2)
                third_next = b;
            if (total_reg != 8'd0)
                check_next = check_reg ^ b;
            total_next = total_reg + 8'd1;

            case (kind_reg)
                KIND_TS:
                begin
                    if (b != TS_DIRECT)
                        err = 1'b1;
                    else
                        kind_next = KIND_T0;
                end
                KIND_T0:
                begin
                    hist_next   = b[3:0];
                    expect_next = sat_add(expect_reg, {4'd0, b[3:0]});
                    iface       = 1'b1;
                end
                KIND_IFACE:
                begin
                    iface = 1'b1;
                end
                KIND_HIST:
                begin
                    if (hist_reg == 4'd0)
                    begin
                        kind_next = KIND_DONE;
                        err       = 1'b1;
                    end
                    else
                    begin
                        hist_next = hist_reg - 4'd1;
                        if (hist_reg == 4'd1)
                        begin
                            if (!dflt_reg && (mask_reg[PROTO_W-1:1] != '0))
                            begin
                                kind_next   = KIND_TCK;
                                expect_next = sat_add(expect_reg, 8'd1);
                            end
                            else
                            begin
                                kind_next = KIND_DONE;
                            end
                        end
                    end
                end
                KIND_TCK:
                begin
                    if (check_next != 8'd0)
                        err = 1'b1;
                    else
                        kind_next = KIND_DONE;
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
        end

        if (iface)
        begin
            // a new group starts with T0 or TD: take presence bits, and protocol for TD
            if (gpos_next == 3'd4)
            begin
                gpos_next = 3'd0;
                if (fmt_seen_next)
                begin
                    if ((mask_next >> ({1'b0, b[3:0]} + 5'd1)) != '0)
                    begin
                        hdr_err = 1'b1;
                    end
                    else
                    begin
                        dflt_next = 1'b0;
                        mask_next = mask_next | (PROTO_W'(1) << b[3:0]);
                    end
                end
                if (!hdr_err)
                begin
                    pres_next     = b[7:4];
                    fmt_seen_next = 1'b1;
                end
            end

            if (hdr_err)
            begin
                err = 1'b1;
            end
            else if (pres_next != 4'd0)
            begin
                // find the next present interface byte in the group
                span = 3'd4 - gpos_next;
                for (int i = 0; i < 4; i++)
                begin
                    if (!found && (3'(i) < span) && pres_next[i])
                    begin
                        found = 1'b1;
                        steps = 3'(i + 1);
                    end
                end
                if (found)
                begin
                    gpos_next   = gpos_next + steps;
                    pres_next   = pres_next >> steps;
                    kind_next   = KIND_IFACE;
                    expect_next = sat_add(expect_next, 8'd1);
                end
                else
                begin
                    gpos_next = 3'd4;
                    pres_next = pres_next >> span;
                end
            end
            else if (hist_next != 4'd0)
            begin
                kind_next = KIND_HIST;
            end
            else if (!dflt_next && (mask_next[PROTO_W-1:1] != '0))
            begin
                kind_next   = KIND_TCK;
                expect_next = sat_add(expect_next, 8'd1);
            end
            else
            begin
                kind_next = KIND_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_TS;
            total_reg     <= 8'd0;
            expect_reg    <= 8'd2;
            pres_reg      <= 4'd0;
            fmt_seen_reg  <= 1'b0;
            gpos_reg      <= 3'd4;
            hist_reg      <= 4'd0;
            mask_reg      <= '0;
            dflt_reg      <= 1'b1;
            check_reg     <= 8'd0;
            fmt_byte_reg  <= 8'd0;
            third_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                kind_reg      <= kind_next;
                total_reg     <= total_next;
                expect_reg    <= expect_next;
                pres_reg      <= pres_next;
                fmt_seen_reg  <= fmt_seen_next;
                gpos_reg      <= gpos_next;
                hist_reg      <= hist_next;
                mask_reg      <= mask_next;
                dflt_reg      <= dflt_next;
                check_reg     <= check_next;
                fmt_byte_reg  <= fmt_byte_next;
                third_reg     <= third_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load with each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg      <= err;
            complete_reg <= (total_next == expect_next);
            count_reg    <= total_next;
            proto_reg    <= mask_next;
            ta1_reg      <= fmt_byte_next[4] ? third_next : TA1_DEFAULT;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.error             = err_reg;
    assign results.complete          = complete_reg;
    assign results.received_count    = count_reg;
    assign results.offered_protocols = proto_reg;
    assign results.ta1_value         = ta1_reg;

endmodule
